/* src/stepper_half_bridge_sequencer_macros.svh */
// assertion macros for the stepper half-bridge sequencer
// expects clk and rst_n in the scope of each use
`ifndef STEPPER_HALF_BRIDGE_SEQUENCER_MACROS_SVH
`define STEPPER_HALF_BRIDGE_SEQUENCER_MACROS_SVH

// property must hold at every clock edge out of reset
`define SHBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SHBS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/shbs_pkg.sv */
// types and constants shared by the stepper half-bridge sequencer
// no dependencies
package shbs_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int NUM_SHADOW = 3;

    localparam logic [1:0] REQ_STEP   = 2'd0;
    localparam logic [1:0] REQ_COILS  = 2'd1;
    localparam logic [1:0] REQ_BRIDGE = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] DRIVE_FWD = 2'd1;
    localparam logic [1:0] DRIVE_REV = 2'd2;

    localparam logic [1:0] LVL_HIGHZ = 2'd0;
    localparam logic [1:0] LVL_LOW   = 2'd1;
    localparam logic [1:0] LVL_HIGH  = 2'd2;

    localparam logic [1:0] CFG_A_PLUS  = 2'd0;
    localparam logic [1:0] CFG_A_MINUS = 2'd1;
    localparam logic [1:0] CFG_B_PLUS  = 2'd2;
    localparam logic [1:0] CFG_B_MINUS = 2'd3;

    localparam logic [3:0] BRIDGE_FIRST = 4'd1;
    localparam logic [3:0] BRIDGE_LAST  = 4'd12;

    localparam logic [3:0] CLEAR_BRIDGE [NUM_SHADOW] = '{4'd1, 4'd5, 4'd9};
    localparam logic [4:0] REG_ADDR [NUM_SHADOW] = '{5'h00, 5'h10, 5'h08};

    localparam logic [1:0] PHASE_DRIVE_A [4] = '{DRIVE_FWD, DRIVE_REV, DRIVE_REV, DRIVE_FWD};
    localparam logic [1:0] PHASE_DRIVE_B [4] = '{DRIVE_FWD, DRIVE_FWD, DRIVE_REV, DRIVE_REV};

    localparam logic       CMD_WRITE = 1'b1;
    localparam logic [1:0] CMD_LOW   = 2'b11;

    typedef struct packed {
        logic       clr;
        logic [3:0] num;
        logic [1:0] lvl;
        logic       last;
    } op_t;

endpackage

/* src/stepper_half_bridge_sequencer.sv */
// top level of the stepper half-bridge sequencer
// depends on shbs_pkg, shbs_front, shbs_fifo, shbs_back
//
// Drives one bipolar stepper through twelve half-bridges held in three shadow
// registers; each bridge update leaves as one beat carrying a command byte and
// a data byte, with last_frame marking the final beat of a request. A request
// is taken and expanded into up to four updates, issued one per cycle while
// the queue has room; the next request is taken in the cycle its
// predecessor's last update enters the queue. The output side retires one
// beat per cycle while out_stall is low. Coil bridge numbers are to be written
// on the cfg port only while no request is in flight; the block itself does
// not enforce this.
module stepper_half_bridge_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [3:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic signed [1:0] step_direction,
    input  logic [1:0]        coil_a_drive,
    input  logic [1:0]        coil_b_drive,
    input  logic [3:0]        bridge_number,
    input  logic [1:0]        bridge_level,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        command_byte,
    output logic [7:0]        data_byte,
    output logic              last_frame
);

    logic          push, push_ready, pop, pop_valid;
    shbs_pkg::op_t push_op, pop_op;

    shbs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .step_direction (step_direction),
        .coil_a_drive   (coil_a_drive),
        .coil_b_drive   (coil_b_drive),
        .bridge_number  (bridge_number),
        .bridge_level   (bridge_level),
        .push           (push),
        .push_op        (push_op),
        .push_ready     (push_ready)
    );

    shbs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_op     (pop_op),
        .pop_valid  (pop_valid)
    );

    shbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_op       (pop_op),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_byte (command_byte),
        .data_byte    (data_byte),
        .last_frame   (last_frame)
    );

endmodule

/* src/shbs_front.sv */
// request decode: config registers, step phase, expansion into bridge updates
// depends on shbs_pkg
module shbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic signed [1:0]   step_direction,
    input  logic [1:0]          coil_a_drive,
    input  logic [1:0]          coil_b_drive,
    input  logic [3:0]          bridge_number,
    input  logic [1:0]          bridge_level,
    output logic                push,
    output shbs_pkg::op_t       push_op,
    input  logic                push_ready
);

    logic [3:0] a_plus_reg, a_minus_reg, b_plus_reg, b_minus_reg;
    logic [1:0] phase_reg, phase_next;
    logic [shbs_pkg::NUM_SLOTS-1:0] mask_reg, mask_next, new_mask, sel_hot;
    logic [3:0] num_reg [shbs_pkg::NUM_SLOTS];
    logic [1:0] lvl_reg [shbs_pkg::NUM_SLOTS];
    logic [3:0] new_num [shbs_pkg::NUM_SLOTS];
    logic [1:0] new_lvl [shbs_pkg::NUM_SLOTS];
    logic       clr_reg, new_clr;
    logic [1:0] sel;
    logic       single, take;
    logic [1:0] drv_a, drv_b;
    logic [3:0] lv_a, lv_b;

    function automatic logic num_ok(logic [3:0] n);
        return (n >= shbs_pkg::BRIDGE_FIRST) && (n <= shbs_pkg::BRIDGE_LAST);
    endfunction

    // {plus level, minus level}
    function automatic logic [3:0] coil_levels(logic [1:0] drive);
        logic [3:0] r;
        if (drive == shbs_pkg::DRIVE_FWD)
            r = {shbs_pkg::LVL_HIGH, shbs_pkg::LVL_LOW};
        else if (drive == shbs_pkg::DRIVE_REV)
            r = {shbs_pkg::LVL_LOW, shbs_pkg::LVL_HIGH};
        else
            r = {shbs_pkg::LVL_HIGHZ, shbs_pkg::LVL_HIGHZ};
        return r;
    endfunction

    always_comb
    begin
        priority if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        sel_hot = '0;
        sel_hot[sel] = 1'b1;
        single = (mask_reg & ~sel_hot) == '0;
    end

    assign push     = (mask_reg != '0) && push_ready;
    assign in_stall = (mask_reg != '0) && !(push && single);
    assign take     = in_valid && !in_stall;

    assign push_op.clr  = clr_reg;
    assign push_op.num  = num_reg[sel];
    assign push_op.lvl  = lvl_reg[sel];
    assign push_op.last = single;

    always_comb
    begin
        phase_next = phase_reg;
        if (step_direction == 2'sd1)
            phase_next = phase_reg + 2'd1;
        else if (step_direction != 2'sd0)
            phase_next = phase_reg + 2'd3;

        if (req_type == shbs_pkg::REQ_STEP)
        begin
            drv_a = shbs_pkg::PHASE_DRIVE_A[phase_next];
            drv_b = shbs_pkg::PHASE_DRIVE_B[phase_next];
        end
        else
        begin
            drv_a = coil_a_drive;
            drv_b = coil_b_drive;
        end
        lv_a = coil_levels(drv_a);
        lv_b = coil_levels(drv_b);

        new_clr = 1'b0;
        new_num[0] = a_plus_reg;
        new_num[1] = a_minus_reg;
        new_num[2] = b_plus_reg;
        new_num[3] = b_minus_reg;
        new_lvl[0] = lv_a[3:2];
        new_lvl[1] = lv_a[1:0];
        new_lvl[2] = lv_b[3:2];
        new_lvl[3] = lv_b[1:0];
        for (int i = 0; i < shbs_pkg::NUM_SLOTS; i++)
            new_mask[i] = num_ok(new_num[i]);

        unique case (req_type)
            shbs_pkg::REQ_STEP:
            begin
                if (step_direction == 2'sd0)
                    new_mask = '0;
            end
            shbs_pkg::REQ_COILS:
            begin
            end
            shbs_pkg::REQ_BRIDGE:
            begin
                new_num[0] = bridge_number;
                new_lvl[0] = bridge_level;
                new_mask = {3'b000, num_ok(bridge_number)};
            end
            shbs_pkg::REQ_CLEAR:
            begin
                new_clr = 1'b1;
                for (int i = 0; i < shbs_pkg::NUM_SHADOW; i++)
                    new_num[i] = shbs_pkg::CLEAR_BRIDGE[i];
                new_mask = 4'b0111;
            end
            default:
            begin
            end
        endcase

        if (take)
            mask_next = new_mask;
        else if (push)
            mask_next = mask_reg & ~sel_hot;
        else
            mask_next = mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_plus_reg  <= 4'd1;
            a_minus_reg <= 4'd2;
            b_plus_reg  <= 4'd3;
            b_minus_reg <= 4'd4;
            phase_reg   <= 2'd0;
            mask_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    shbs_pkg::CFG_A_PLUS:  a_plus_reg  <= cfg_data;
                    shbs_pkg::CFG_A_MINUS: a_minus_reg <= cfg_data;
                    shbs_pkg::CFG_B_PLUS:  b_plus_reg  <= cfg_data;
                    shbs_pkg::CFG_B_MINUS: b_minus_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (take && req_type == shbs_pkg::REQ_STEP)
                phase_reg <= phase_next;
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            clr_reg <= new_clr;
            for (int i = 0; i < shbs_pkg::NUM_SLOTS; i++)
            begin
                num_reg[i] <= new_num[i];
                lvl_reg[i] <= new_lvl[i];
            end
        end
    end

endmodule

/* src/shbs_fifo.sv */
// short queue of bridge updates between decode and frame output
// depends on shbs_pkg and the assertion macro header
`include "stepper_half_bridge_sequencer_macros.svh"

module shbs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  shbs_pkg::op_t push_op,
    output logic          push_ready,
    input  logic          pop,
    output shbs_pkg::op_t pop_op,
    output logic          pop_valid
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    shbs_pkg::op_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_op     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_op;
    end

    `SHBS_NEVER(a_no_overflow, push && !push_ready, "push into full queue")
    `SHBS_NEVER(a_no_underflow, pop && !pop_valid, "pop from empty queue")
    `SHBS_ASSERT(a_count_bound, count_reg <= CNT_FULL, "queue count out of range")
    `SHBS_ASSERT(a_ptr_track, (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg), "pointers differ when empty")

endmodule

/* src/shbs_back.sv */
// shadow registers and serial write frame output register
// depends on shbs_pkg
module shbs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    input  shbs_pkg::op_t pop_op,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    command_byte,
    output logic [7:0]    data_byte,
    output logic          last_frame
);

    logic [7:0] shadow_reg [shbs_pkg::NUM_SHADOW];
    logic       out_valid_reg;
    logic [7:0] cmd_reg, data_reg;
    logic       last_reg;
    logic [3:0] num_m1;
    logic [1:0] idx;
    logic [2:0] shift;
    logic [7:0] cur, new_val;

    assign pop    = pop_valid && (!out_valid_reg || !out_stall);
    assign num_m1 = pop_op.num - 4'd1;
    assign idx    = num_m1[3:2];
    assign shift  = {num_m1[1:0], 1'b0};

    always_comb
    begin
        cur = 8'h00;
        for (int i = 0; i < shbs_pkg::NUM_SHADOW; i++)
            if (idx == 2'(i))
                cur = shadow_reg[i];
        if (pop_op.clr)
            new_val = 8'h00;
        else
            new_val = (cur & ~(8'h03 << shift)) | ({6'b0, pop_op.lvl} << shift);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < shbs_pkg::NUM_SHADOW; i++)
                shadow_reg[i] <= 8'h00;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < shbs_pkg::NUM_SHADOW; i++)
                    if (idx == 2'(i))
                        shadow_reg[i] <= new_val;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= {shbs_pkg::CMD_WRITE, shbs_pkg::REG_ADDR[idx], shbs_pkg::CMD_LOW};
            data_reg <= new_val;
            last_reg <= pop_op.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_byte = cmd_reg;
    assign data_byte    = data_reg;
    assign last_frame   = last_reg;

endmodule
